// ----- hdl/sha256bsh_pkg.sv -----
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// Depends on nothing; the other files, but for the interfaces, refer to it by scoped names.
`default_nettype none

package sha256bsh_pkg;

  localparam int WordW    = 32;
  localparam int NumChain = 8;
  localparam int BufDepth = 16;
  localparam int Rounds   = 64;
  localparam int CountW   = 61;
  localparam int PadLimit = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // controls for the round unit and chain value
  typedef struct packed {
    logic       init;
    logic       load;
    logic       round;
    logic       fold;
    logic [5:0] rnd;
  } rnd_ctl_t;

  // controls for the block buffer and schedule
  typedef struct packed {
    logic              put;
    logic [5:0]        pos;
    logic [7:0]        data;
    logic              put_len;
    logic [CountW-1:0] count;
    logic              shift;
    logic              clear;
  } sch_ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t v;
    unique case (idx)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sha256bsh_ifs.sv -----
// Valid/ready channel interfaces for the byte input and the digest output.
// Depends on nothing.
`default_nettype none

interface sha256bsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, byte_value, byte_present, is_last, input ready);
  modport sink   (input valid, byte_value, byte_present, is_last, output ready);
endinterface

interface sha256bsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/sha256bsh_sched.sv -----
// Block buffer and message schedule: byte packing, length words, W shift line.
// Depends on sha256bsh_pkg.
`default_nettype none

module sha256bsh_sched (
  input  wire                       clk,
  input  wire                       rst_n,
  input  sha256bsh_pkg::sch_ctl_t   ctl,
  output sha256bsh_pkg::word_t      w_out
);

  sha256bsh_pkg::word_t buf_r [sha256bsh_pkg::BufDepth];
  sha256bsh_pkg::word_t w_new;
  sha256bsh_pkg::word_t byte_word;
  logic [63:0]          bit_len;
  logic [3:0]           wsel;
  logic [4:0]           bsh;

  assign wsel      = ctl.pos[5:2];
  assign bsh       = {~ctl.pos[1:0], 3'b000};
  assign byte_word = sha256bsh_pkg::word_t'(ctl.data) << bsh;
  assign bit_len   = {ctl.count, 3'b000};
  assign w_new     = sha256bsh_pkg::small_sig1(buf_r[14]) + buf_r[9]
                   + sha256bsh_pkg::small_sig0(buf_r[1]) + buf_r[0];
  assign w_out     = buf_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < sha256bsh_pkg::BufDepth; i++) buf_r[i] <= '0;
    end else if (ctl.shift) begin
      for (int i = 0; i < sha256bsh_pkg::BufDepth - 1; i++) buf_r[i] <= buf_r[i+1];
      buf_r[sha256bsh_pkg::BufDepth-1] <= w_new;
    end else begin
      if (ctl.put) buf_r[wsel] <= buf_r[wsel] | byte_word;
      if (ctl.put_len) begin
        buf_r[14] <= bit_len[63:32];
        buf_r[15] <= bit_len[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sha256bsh_round.sv -----
// Shared compression round unit with working variables and chain value.
// Depends on sha256bsh_pkg.
`default_nettype none

module sha256bsh_round (
  input  wire                       clk,
  input  wire                       rst_n,
  input  sha256bsh_pkg::rnd_ctl_t   ctl,
  input  sha256bsh_pkg::word_t      w_in,
  input  wire [2:0]                 rd_idx,
  output sha256bsh_pkg::word_t      rd_word
);

  sha256bsh_pkg::word_t chain_r [sha256bsh_pkg::NumChain];
  sha256bsh_pkg::word_t var_r   [sha256bsh_pkg::NumChain];
  sha256bsh_pkg::word_t t1, t2, ch, maj;

  assign ch  = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
  assign maj = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
  assign t1  = var_r[7] + sha256bsh_pkg::big_sig1(var_r[4]) + ch
             + sha256bsh_pkg::round_k(ctl.rnd) + w_in;
  assign t2  = sha256bsh_pkg::big_sig0(var_r[0]) + maj;

  assign rd_word = chain_r[rd_idx];

  // chain value: initial hash after reset and after each digest
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < sha256bsh_pkg::NumChain; i++)
        chain_r[i] <= sha256bsh_pkg::init_hash(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < sha256bsh_pkg::NumChain; i++)
        chain_r[i] <= chain_r[i] + var_r[i];
    end
  end

  // working variables: one round per cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < sha256bsh_pkg::NumChain; i++) var_r[i] <= chain_r[i];
    end else if (ctl.round) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sha256_byte_stream_hasher_unit.sv -----
// SHA-256 byte stream hasher, top level: sequencer around one shared round unit.
// A byte word is taken while idle; the 64th byte of a block starts 64 rounds and then the fold.
// A last word runs pad, length, rounds and fold before the digest, or pad, rounds, fold, length,
// rounds and fold when the padding spills into a second block; eight digest words then follow,
// one per accepted cycle. No byte is taken while the round unit works, so it sets the sustained rate.
// Synchronous active-low reset loads the initial hash, clears buffer, count and sequencer.
`default_nettype none

module sha256_byte_stream_hasher_unit (
  input  wire                    clk,
  input  wire                    rst_n,
  sha256bsh_in_if.sink           in_ch,
  sha256bsh_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_LEN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [sha256bsh_pkg::CountW-1:0] count_r, count_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;   // message end seen, digest pending
  logic       pad_r, pad_nxt;   // 0x80 byte placed
  logic       len_r, len_nxt;   // length block compressed or under way
  logic [5:0] pos;
  logic       in_acc;
  logic       out_acc;

  sha256bsh_pkg::rnd_ctl_t rctl;
  sha256bsh_pkg::sch_ctl_t sctl;
  sha256bsh_pkg::word_t    w_cur;
  sha256bsh_pkg::word_t    digest;

  assign pos     = count_r[5:0];
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    pad_nxt   = pad_r;
    len_nxt   = len_r;
    rctl      = '0;
    rctl.rnd  = rnd_r;
    sctl       = '0;
    sctl.pos   = pos;
    sctl.data  = in_ch.byte_value;
    sctl.count = count_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // ready is held high here, so valid alone marks an accepted word
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          // take the byte first, then compress on a full block or finish on last
          if (in_ch.byte_present) begin
            sctl.put  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_ch.byte_present && pos == 6'(sha256bsh_pkg::Rounds - 1)) begin
            rctl.load = 1'b1;
            rnd_nxt   = '0;
            fin_nxt   = in_ch.is_last;
            state_nxt = S_ROUND;
          end else if (in_ch.is_last) begin
            fin_nxt   = 1'b1;
            state_nxt = S_PAD;
          end
        end
      end

      S_ROUND: begin
        // one round per cycle; the schedule line advances alongside
        rctl.round = 1'b1;
        sctl.shift = 1'b1;
        rnd_nxt    = rnd_r + 1'b1;
        if (rnd_r == 6'(sha256bsh_pkg::Rounds - 1)) state_nxt = S_FOLD;
      end

      S_FOLD: begin
        // fold into the chain value and drop the spent block
        rctl.fold  = 1'b1;
        sctl.clear = 1'b1;
        priority if (!fin_r) state_nxt = S_IDLE;
        else if (!pad_r)     state_nxt = S_PAD;
        else if (!len_r)     state_nxt = S_LEN;
        else                 state_nxt = S_EMIT;
      end

      S_PAD: begin
        sctl.put  = 1'b1;
        sctl.data = sha256bsh_pkg::PadByte;
        pad_nxt   = 1'b1;
        if (pos >= 6'(sha256bsh_pkg::PadLimit)) begin
          // no room for the length: compress this block first
          rctl.load = 1'b1;
          rnd_nxt   = '0;
          state_nxt = S_ROUND;
        end else begin
          state_nxt = S_LEN;
        end
      end

      S_LEN: begin
        sctl.put_len = 1'b1;
        len_nxt      = 1'b1;
        rctl.load    = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = S_ROUND;
      end

      S_EMIT: begin
        // valid is held high here, so ready alone marks a taken digest word
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 3'(sha256bsh_pkg::NumChain - 1)) begin
            // hand back to the initial state for the next message
            rctl.init = 1'b1;
            count_nxt = '0;
            fin_nxt   = 1'b0;
            pad_nxt   = 1'b0;
            len_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      len_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      len_r   <= len_nxt;
    end
  end

  sha256bsh_sched u_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sctl),
    .w_out (w_cur)
  );

  sha256bsh_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rctl),
    .w_in    (w_cur),
    .rd_idx  (idx_r),
    .rd_word (digest)
  );

  // digest words read straight from the chain registers, which hold while emitting
  assign out_ch.digest_word = digest;
  assign out_ch.word_index  = idx_r;
  assign out_ch.digest_last = (idx_r == 3'(sha256bsh_pkg::NumChain - 1));

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while digest words pending");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.is_last) |=> !in_ch.ready)
    else $error("ready right after a last word");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.digest_last) |=> (in_ch.ready && !out_ch.valid))
    else $error("not idle after final digest word");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'(sha256bsh_pkg::Rounds - 1)) |=> (state_r == S_FOLD))
    else $error("compression did not fold after the last round");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the SHA-256 byte stream hasher (sha256_byte_stream_hasher_unit).
// Depends on hdl/sha256bsh_pkg.sv, hdl/sha256bsh_ifs.sv and the hdl design files; the predictor is written out here.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 12;
  localparam int CycleLimit = 400000;   // several times what the slowest correct run needs
  localparam int ItemTarget = 320;
  localparam int TailCycles = 160;      // two-block finish plus eight digest words, with margin
  localparam int NumRows    = 14;

  // FIPS 180-4 round constants, K[0] in the top word
  localparam logic [64*32-1:0] RoundConsts = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value, H0 in the top word
  localparam logic [255:0] InitChain = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // well-known digests, typed in for the directed rows
  localparam logic [255:0] DigestEmpty =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DigestAbc =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  typedef struct packed {
    sha256bsh_pkg::word_t digest_word;
    logic [2:0]           word_index;
    logic                 digest_last;
  } digest_item_t;

  typedef struct packed {
    logic [7:0]   byte_value;
    logic         byte_present;
    logic         is_last;
    logic         known;        // digest typed in below rather than predicted
    logic [255:0] digest;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic steady;                 // high while neither side may idle

  sha256bsh_in_if  in_ch ();
  sha256bsh_out_if out_ch ();

  sha256_byte_stream_hasher_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: running chain value, partly filled block, message length
  // ---------------------------------------------------------------------------
  sha256bsh_pkg::word_t hash_chain [8];
  sha256bsh_pkg::word_t msg_block  [16];
  logic [60:0]  msg_bytes;      // wraps at 61 bits, so the bit length wraps at 64

  digest_item_t digest_q [$];   // digest words still owed by the block

  int unsigned cycles;
  int unsigned errors;
  int unsigned n_items;         // words carrying a byte or a message end; idle words excluded
  int unsigned n_noise;
  int unsigned n_msgs;
  int unsigned n_checked;
  int unsigned n_two_block;     // messages whose padding spilled into a second block

  stim_row_t dir_tab [NumRows];

  function automatic sha256bsh_pkg::word_t ror32(input sha256bsh_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < 8; i++) hash_chain[i] = InitChain[255 - 32*i -: 32];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    msg_bytes = '0;
  endfunction

  // Fold the current block into the chain value, then clear the block.
  function automatic void fold_block();
    sha256bsh_pkg::word_t sched [64];
    sha256bsh_pkg::word_t v [8];
    sha256bsh_pkg::word_t x, y, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      x = sched[i-15];
      y = sched[i-2];
      sched[i] = (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10)) + sched[i-7]
               + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + sched[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConsts[2047 - 32*i -: 32] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
  endfunction

  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
    msg_block[pos[5:2]] = msg_block[pos[5:2]]
                        | (sha256bsh_pkg::word_t'(b) << (24 - 8*pos[1:0]));
  endfunction

  // Advance the hash by one accepted input word; on a message end hand back the digest.
  function automatic void hash_take_word(input logic [7:0] b, input logic present,
                                         input logic last, output logic done,
                                         output logic [255:0] digest);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    done   = 1'b0;
    digest = '0;
    if (present) begin
      pos = msg_bytes[5:0];
      place_byte(pos, b);
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 6'd63) fold_block();
    end
    if (last) begin
      pos = msg_bytes[5:0];
      place_byte(pos, sha256bsh_pkg::PadByte);
      if (pos >= 6'(sha256bsh_pkg::PadLimit)) begin
        fold_block();
        n_two_block++;
      end
      bit_len = {msg_bytes, 3'b000};
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      fold_block();
      for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = hash_chain[i];
      done = 1'b1;
      restart_chain();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod/2) clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycles, digest_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: present one word at a falling edge, hold it until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic present, input logic last,
                           input logic known, input logic [255:0] known_digest);
    logic         done;
    logic [255:0] digest;
    digest_item_t owed;
    // idle now and then, never inside the steady stretch
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.byte_value   <= b;
    in_ch.byte_present <= present;
    in_ch.is_last      <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // the word is taken at this edge: advance the prediction
    hash_take_word(b, present, last, done, digest);
    if (done) begin
      if (known) digest = known_digest;
      for (int k = 0; k < 8; k++) begin
        owed = '{digest_word: digest[255 - 32*k -: 32],
                 word_index: 3'(k), digest_last: (k == 7)};
        digest_q = {digest_q, owed};
      end
      n_msgs++;
    end
    if (present || last) n_items++;
    else n_noise++;
    // hold no idling for a long stretch in the middle of the random part
    steady <= (n_items >= 200 && n_items < 260);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed digest word has come out.
  task automatic drain_digests();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, check every accepted digest word
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk) begin : check_digest
    digest_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected digest word %08h index %0d last %0b", $realtime,
                   out_ch.digest_word, out_ch.word_index, out_ch.digest_last);
      end else begin
        want = digest_q.pop_front();
        n_checked++;
        if (out_ch.digest_word !== want.digest_word || out_ch.word_index !== want.word_index
            || out_ch.digest_last !== want.digest_last) begin
          errors++;
          if (errors <= 10)
            $display("%0t: digest mismatch: word %08h/%08h index %0d/%0d last %0b/%0b %s",
                     $realtime, out_ch.digest_word, want.digest_word, out_ch.word_index,
                     want.word_index, out_ch.digest_last, want.digest_last, "(got/exp)");
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned  len;
    logic         end_on_byte;
    int unsigned  forced [3];
    int unsigned  edge_lens [10];
    int unsigned  msg_no;
    logic         paused;

    forced    = '{55, 56, 64};    // last length fitting one block, first spilling, full block
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    // directed rows: idle words, empty message, "abc", single bytes at both extremes,
    // a byte then an end without a byte, idle words mid-message, empty again after a digest
    dir_tab = '{
      {8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
      {8'h00, 1'b0, 1'b1, 1'b1, DigestEmpty},
      {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h63, 1'b1, 1'b1, 1'b1, DigestAbc},
      {8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
      {8'h00, 1'b0, 1'b1, 1'b0, 256'h0},
      {8'ha5, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'hff, 1'b0, 1'b1, 1'b0, 256'h0},
      {8'h5a, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'h80, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'hc3, 1'b0, 1'b1, 1'b1, DigestEmpty}
    };

    errors      = 0;
    n_items     = 0;
    n_noise     = 0;
    n_msgs      = 0;
    n_checked   = 0;
    n_two_block = 0;
    restart_chain();

    // drive every input known before the first edge and assert reset; release it at a falling edge
    steady             = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.byte_value   = '0;
    in_ch.byte_present = 1'b0;
    in_ch.is_last      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[r])
      send_word(dir_tab[r].byte_value, dir_tab[r].byte_present, dir_tab[r].is_last,
                dir_tab[r].known, dir_tab[r].digest);

    // let the directed digests drain before the random part starts
    drain_digests();

    // Random messages: first the padding boundaries, then mostly short messages with an
    // occasional boundary length. Idle words are scattered through as noise.
    msg_no = 0;
    paused = 1'b0;
    while (n_items < ItemTarget) begin
      if (msg_no < 3) len = forced[msg_no];
      else if ($urandom_range(0, 7) == 0) len = edge_lens[$urandom_range(0, 9)];
      else len = $urandom_range(0, 12);
      end_on_byte = (len != 0) && $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1), 1'b0, '0);
      end
      if (!end_on_byte)
        send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      msg_no++;
      // pause the sender once mid-run until the block has nothing left to give
      if (!paused && n_items >= 280) begin
        drain_digests();
        paused = 1'b1;
      end
    end

    in_ch.valid <= 1'b0;
    steady      <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (digest_q.size() != 0) errors++;
    $display("summary: %0d messages, %0d input words (+%0d idle), %0d digest words checked",
             n_msgs, n_items, n_noise, n_checked);
    $display("summary: %0d messages padded into a second block, %0d mismatches",
             n_two_block, errors);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
